>>> src/dlpo_pkg.sv
// Package for the dust sensor low-pulse occupancy meter.
// Shared widths, defaults and fixed-point constants; no dependencies.
`timescale 1ns / 1ps

package dlpo_pkg;

    localparam int DEF_COUNT_WIDTH     = 32;
    localparam int DEF_RATIO_FRAC_BITS = 16;

    localparam int WLEN_W     = 30;
    localparam int WLEN_RESET = 30000000;

    localparam int RATIO_W = 23;
    localparam int CONC_W  = 25;
    localparam int TDATA_W = 48;
    localparam int TIN_W   = 8;

    localparam int QUEUE_DEPTH = 2;

    // Cubic in Q16: 110*p3 - 380*p2 + 52000*p + 62*65536, then / (2^14 * 25)
    localparam int P16_W  = 23;
    localparam int P2_W   = 30;
    localparam int P3_W   = 37;
    localparam int ACC_W  = 46;
    localparam int CUBE_Q = 16;

    localparam longint COEF_P3    = 110;
    localparam longint COEF_P2    = 380;
    localparam longint COEF_P1    = 52000;
    localparam longint COEF_P0    = 62 * 65536;
    localparam int     DIV_SHIFT  = 14;
    localparam int     X_W        = 29;

    // x / 25 as (x * ceil(2^34 / 25)) >> 34, exact for x below 2^30
    localparam longint DIV_RECIP    = 687194768;
    localparam int     DIV_RECIP_W  = 30;
    localparam int     DIV_RECIP_SH = 34;

endpackage

>>> src/dlpo_queue.sv
// Short queue of closed windows between the tick front end and the math back end.
// Depends on dlpo_pkg for the queue depth.
`timescale 1ns / 1ps

module dlpo_queue import dlpo_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_COUNT_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

>>> src/dlpo_front.sv
// Tick front end: pulse timing, window accounting and the window_length register.
// Depends on dlpo_pkg; pushes closed windows into dlpo_queue.
`timescale 1ns / 1ps

module dlpo_front import dlpo_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [WLEN_W-1:0]      cfg_wdata,
    input  logic                   tick_valid,
    output logic                   tick_ready,
    input  logic                   pin_level,
    input  logic                   q_full,
    output logic                   push,
    output logic [COUNT_WIDTH-1:0] push_total,
    output logic [COUNT_WIDTH-1:0] push_elapsed
);

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > WLEN_W) ? CW : WLEN_W;

    logic [WLEN_W-1:0] wlen_reg;
    logic              prev_reg;
    logic              armed_reg;
    logic [CW-1:0]     run_reg;
    logic [CW-1:0]     total_reg;
    logic [CW-1:0]     elapsed_reg;

    logic              prev_next;
    logic              armed_next;
    logic [CW-1:0]     run_next;
    logic [CW-1:0]     total_next;
    logic [CW-1:0]     elapsed_next;
    logic              accept;
    logic              close;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    assign tick_ready = !q_full;
    assign accept     = tick_valid && !q_full;

    always_comb
    begin
        elapsed_next = sat_add(elapsed_reg, CW'(1));
        armed_next   = armed_reg;
        run_next     = run_reg;
        total_next   = total_reg;
        prev_next    = pin_level;
        if (!pin_level)
        begin
            if (prev_reg)
            begin
                armed_next = 1'b1;
                run_next   = CW'(1);
            end
            else if (armed_reg)
            begin
                run_next = sat_add(run_reg, CW'(1));
            end
        end
        else if (!prev_reg && armed_reg)
        begin
            total_next = sat_add(total_reg, run_reg);
            run_next   = '0;
            armed_next = 1'b0;
        end
        close = (CMP_W'(elapsed_next) >= CMP_W'(wlen_reg));
    end

    assign push         = accept && close;
    assign push_total   = total_next;
    assign push_elapsed = elapsed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg    <= WLEN_W'(WLEN_RESET);
            prev_reg    <= 1'b1;
            armed_reg   <= 1'b0;
            run_reg     <= '0;
            total_reg   <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                wlen_reg <= cfg_wdata;
            end
            if (accept)
            begin
                prev_reg  <= prev_next;
                armed_reg <= armed_next;
                run_reg   <= run_next;
                if (close)
                begin
                    total_reg   <= '0;
                    elapsed_reg <= '0;
                end
                else
                begin
                    total_reg   <= total_next;
                    elapsed_reg <= elapsed_next;
                end
            end
        end
    end

endmodule

>>> src/dlpo_back.sv
// Math back end: serial ratio divider, staged cubic, reciprocal divide by 25, output register.
// Depends on dlpo_pkg; pops closed windows from dlpo_queue.
`timescale 1ns / 1ps

module dlpo_back import dlpo_pkg::*;
#(
    parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH,
    parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [COUNT_WIDTH-1:0] q_total,
    input  logic [COUNT_WIDTH-1:0] q_elapsed,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata
);

    localparam int CW     = COUNT_WIDTH;
    localparam int QW     = 7 + RATIO_FRAC_BITS;
    localparam int NW     = CW + 7;
    localparam int STEP_W = $clog2(QW + 1);
    localparam int PROD_W = X_W + DIV_RECIP_W;
    localparam logic [QW-1:0] RATIO_FULL = QW'(100) << RATIO_FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_P2,
        ST_P3,
        ST_TERMS,
        ST_SUM,
        ST_D25,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic                m_tvalid_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [CW-1:0]       part_reg;
    logic [CW-1:0]       whole_reg;
    logic [CW-1:0]       rem_reg;
    logic [6:0]          nbits_reg;
    logic [QW-1:0]       q_reg;
    logic [P2_W-1:0]     p2_reg;
    logic [P3_W-1:0]     p3_reg;
    logic [ACC_W-1:0]    ta_reg;
    logic [ACC_W-1:0]    tb_reg;
    logic [X_W-1:0]      x_reg;
    logic [CONC_W-1:0]   quot_reg;
    logic [RATIO_W-1:0]  ratio_out_reg;
    logic [CONC_W-1:0]   conc_out_reg;

    logic [NW-1:0]       num;
    logic [CW:0]         dstep;
    logic                dge;
    logic [CW:0]         ddiff;
    logic [QW+15:0]      q_wide;
    logic [P16_W-1:0]    p16;
    logic [2*P16_W-1:0]  sq;
    logic [P2_W+P16_W-1:0] cube;
    logic [ACC_W-1:0]    acc;
    logic [PROD_W-1:0]   recip_prod;
    logic                out_free;

    assign num     = NW'(part_reg) * NW'(100);
    assign dstep   = {rem_reg, nbits_reg[6]};
    assign dge     = (dstep >= {1'b0, whole_reg});
    assign ddiff   = dstep - {1'b0, whole_reg};
    assign q_wide  = {q_reg, 16'b0} >> RATIO_FRAC_BITS;
    assign p16     = q_wide[P16_W-1:0];
    assign sq      = p16 * p16;
    assign cube    = p2_reg * p16;
    assign acc     = ta_reg + tb_reg;
    assign recip_prod = PROD_W'(x_reg) * PROD_W'(DIV_RECIP);
    assign out_free = !m_tvalid_reg || m_tready;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {conc_out_reg, ratio_out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            step_reg      <= '0;
            ratio_out_reg <= '0;
            conc_out_reg  <= '0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg  <= 1'b1;
                ratio_out_reg <= RATIO_W'(q_reg);
                conc_out_reg  <= quot_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    step_reg  <= '0;
                    state_reg <= (part_reg >= whole_reg) ? ST_P2 : ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(QW - 1))
                    begin
                        state_reg <= ST_P2;
                    end
                end
                ST_P2:    state_reg <= ST_P3;
                ST_P3:    state_reg <= ST_TERMS;
                ST_TERMS: state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_D25;
                ST_D25:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                part_reg  <= q_total;
                whole_reg <= q_elapsed;
            end
            ST_MUL:
            begin
                rem_reg   <= num[NW-1:7];
                nbits_reg <= num[6:0];
                q_reg     <= (part_reg >= whole_reg) ? RATIO_FULL : '0;
            end
            ST_DIV:
            begin
                rem_reg   <= dge ? ddiff[CW-1:0] : dstep[CW-1:0];
                nbits_reg <= {nbits_reg[5:0], 1'b0};
                q_reg     <= {q_reg[QW-2:0], dge};
            end
            ST_P2:
            begin
                p2_reg <= sq[CUBE_Q+P2_W-1:CUBE_Q];
            end
            ST_P3:
            begin
                p3_reg <= cube[CUBE_Q+P3_W-1:CUBE_Q];
            end
            ST_TERMS:
            begin
                ta_reg <= ACC_W'(p3_reg) * ACC_W'(COEF_P3);
                tb_reg <= ACC_W'(p16) * ACC_W'(COEF_P1) + ACC_W'(COEF_P0)
                          - ACC_W'(p2_reg) * ACC_W'(COEF_P2);
            end
            ST_SUM:
            begin
                x_reg <= acc[ACC_W-1] ? '0 : acc[DIV_SHIFT+X_W-1:DIV_SHIFT];
            end
            ST_D25:
            begin
                quot_reg <= recip_prod[DIV_RECIP_SH+CONC_W-1:DIV_RECIP_SH];
            end
            default:
            begin
            end
        endcase
    end

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < whole_reg))
        else $error("ratio remainder not below divisor");
    a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P2) |-> (q_reg <= RATIO_FULL))
        else $error("ratio above 100 percent");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending transaction");

endmodule

>>> src/dust_low_pulse_occupancy.sv
// Top level of the dust sensor low-pulse occupancy meter.
// Depends on dlpo_pkg, dlpo_front, dlpo_queue and dlpo_back.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | s_tdata[0] pin_level; one transaction per tick
//   m_*      | out       | m_tdata[22:0] low_ratio, [47:23] concentration
//   cfg_*    | in        | cfg_wdata window_length, written when cfg_wen
//
// A tick is taken every cycle while the window queue has room.
// A closed window passes in the back end through the serial ratio divider
// (7 + RATIO_FRAC_BITS steps) and eight further stages;
// a ratio saturated at 100 percent skips the divider.
// Reset clears all counters and loads window_length with 30000000.
// A stalled m_tready holds one result while the back end computes the next;
// s_tready drops only when two closed windows are queued.
`timescale 1ns / 1ps

module dust_low_pulse_occupancy import dlpo_pkg::*;
#(
    parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH,
    parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [WLEN_W-1:0]  cfg_wdata,   // window_length
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TIN_W-1:0]   s_tdata,     // [0] pin_level, [7:1] zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata      // [22:0] low_ratio, [47:23] concentration
);

    localparam int QWIDTH = 2 * COUNT_WIDTH;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [COUNT_WIDTH-1:0] push_total;
    logic [COUNT_WIDTH-1:0] push_elapsed;
    logic [QWIDTH-1:0]      q_rdata;

    dlpo_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .tick_valid   (s_tvalid),
        .tick_ready   (s_tready),
        .pin_level    (s_tdata[0]),
        .q_full       (q_full),
        .push         (q_push),
        .push_total   (push_total),
        .push_elapsed (push_elapsed)
    );

    dlpo_queue #(
        .WIDTH (QWIDTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({push_elapsed, push_total}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    dlpo_back #(
        .COUNT_WIDTH     (COUNT_WIDTH),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_total   (q_rdata[COUNT_WIDTH-1:0]),
        .q_elapsed (q_rdata[QWIDTH-1:COUNT_WIDTH]),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> tb/tb_dust_low_pulse_occupancy.sv
// Self-checking testbench for the dust sensor low-pulse occupancy meter.
// Drives pin-level ticks and several window lengths, and checks every window result
// against an in-bench occupancy model; depends on dlpo_pkg and dust_low_pulse_occupancy.
`timescale 1ns / 1ps

module tb_dust_low_pulse_occupancy;
    import dlpo_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SETTLE_CYCLES = 80;
    localparam longint CONC_DIVISOR = 409600;
    localparam longint CONC_MAX     = (64'd1 << CONC_W) - 1;
    localparam longint FULL_SCALE   = 64'd100 << DEF_RATIO_FRAC_BITS;

    typedef logic [DEF_COUNT_WIDTH-1:0] count_t;

    typedef struct packed
    {
        logic [CONC_W-1:0]  concentration;
        logic [RATIO_W-1:0] low_ratio;
    } window_result_t;

    class occupancy_scoreboard;
        logic [WLEN_W-1:0] window_length;
        logic              previous_level;
        logic              low_armed;
        count_t            low_run;
        count_t            low_total;
        count_t            window_elapsed;
        window_result_t    pending[$];
        int                mismatches;
        int                ticks;
        int                windows;
        int                saturated;

        function void clear();
            window_length  = WLEN_W'(WLEN_RESET);
            previous_level = 1'b1;
            low_armed      = 1'b0;
            low_run        = '0;
            low_total      = '0;
            window_elapsed = '0;
            pending.delete();
            mismatches     = 0;
            ticks          = 0;
            windows        = 0;
            saturated      = 0;
        endfunction

        function void set_window(logic [WLEN_W-1:0] len);
            window_length = len;
        endfunction

        function count_t bump(count_t a, count_t b);
            logic [DEF_COUNT_WIDTH:0] sum;
            sum = a + b;
            return sum[DEF_COUNT_WIDTH] ? '1 : sum[DEF_COUNT_WIDTH-1:0];
        endfunction

        // percent with fraction bits, long division, saturated at 100
        function longint unsigned low_percent(count_t part, count_t whole);
            longint unsigned q;
            longint unsigned r;
            longint unsigned w;
            if (part >= whole)
                return FULL_SCALE;
            w = whole;
            q = (longint'(part) * 100) / w;
            r = (longint'(part) * 100) % w;
            for (int i = 0; i < DEF_RATIO_FRAC_BITS; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= w)
                begin
                    r = r - w;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function logic [CONC_W-1:0] dust_concentration(longint unsigned ratio);
            longint unsigned p16;
            longint unsigned p2;
            longint unsigned p3;
            longint          acc;
            if (DEF_RATIO_FRAC_BITS >= 16)
                p16 = ratio >> (DEF_RATIO_FRAC_BITS - 16);
            else
                p16 = ratio << (16 - DEF_RATIO_FRAC_BITS);
            p2  = (p16 * p16) >> 16;
            p3  = (p2 * p16) >> 16;
            acc = COEF_P3 * longint'(p3) - COEF_P2 * longint'(p2)
                  + COEF_P1 * longint'(p16) + COEF_P0;
            if (acc < 0)
                return '0;
            acc = acc / CONC_DIVISOR;
            if (acc > CONC_MAX)
                return '1;
            return acc[CONC_W-1:0];
        endfunction

        function void take_tick(logic pin);
            window_result_t  res;
            longint unsigned ratio;
            ticks++;
            window_elapsed = bump(window_elapsed, count_t'(1));
            if (!pin)
            begin
                if (previous_level)
                begin
                    low_armed = 1'b1;
                    low_run   = count_t'(1);
                end
                else if (low_armed)
                    low_run = bump(low_run, count_t'(1));
            end
            else if (!previous_level && low_armed)
            begin
                low_total = bump(low_total, low_run);
                low_run   = '0;
                low_armed = 1'b0;
            end
            previous_level = pin;
            if (window_elapsed >= count_t'(window_length))
            begin
                ratio             = low_percent(low_total, window_elapsed);
                res.low_ratio     = ratio[RATIO_W-1:0];
                res.concentration = dust_concentration(ratio);
                pending.push_back(res);
                if (ratio == FULL_SCALE)
                    saturated++;
                window_elapsed = '0;
                low_total      = '0;
            end
        endfunction

        function void check_window(window_result_t got);
            window_result_t want;
            if (pending.size() == 0)
            begin
                $error("window result with none expected: low_ratio %0d concentration %0d",
                       got.low_ratio, got.concentration);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            windows++;
            if (got.low_ratio !== want.low_ratio)
            begin
                $error("low_ratio: expected %0d, actual %0d", want.low_ratio, got.low_ratio);
                mismatches++;
            end
            if (got.concentration !== want.concentration)
            begin
                $error("concentration: expected %0d, actual %0d",
                       want.concentration, got.concentration);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_wen   = 1'b0;
    logic [WLEN_W-1:0]  cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TIN_W-1:0]   s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    occupancy_scoreboard tracker = new;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;

    dust_low_pulse_occupancy dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [0] pin_level, [7:1] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)      // [22:0] low_ratio, [47:23] concentration
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_window(window_result_t'(m_tdata));
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_dust_low_pulse_occupancy failed");
            $finish;
        end
    end

    task automatic write_window(input int len);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_wdata = WLEN_W'(len);
        @(negedge clk);
        cfg_wen   = 1'b0;
        tracker.set_window(WLEN_W'(len));
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_tick(input logic pin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(TIN_W-1){1'b0}}, pin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_tick(pin);
        @(negedge clk);
    endtask

    task automatic send_levels(input logic levels[$]);
        foreach (levels[i])
            send_tick(levels[i]);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // low/high pulses of random length, with glitches and overlong runs of either level mixed in
    task automatic pulse_phase(input int len, input int n, input int pulse_max);
        int   sent;
        int   run;
        logic level;
        sent  = 0;
        level = 1'($urandom_range(1));
        write_window(len);
        while (sent < n)
        begin
            case ($urandom_range(9))
                0:       run = 1;
                1:       run = $urandom_range(1, 4 * pulse_max);
                default: run = $urandom_range(1, pulse_max);
            endcase
            for (int k = 0; k < run && sent < n; k++)
            begin
                send_tick(level);
                sent++;
            end
            level = ~level;
        end
        s_tvalid = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        tracker.clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero window: a result on every tick
        write_window(0);
        send_levels('{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1});
        wait_drained();
        // low pulse longer than the window, crossing two window ends
        write_window(4);
        send_levels('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b1, 1'b1, 1'b1});
        wait_drained();
        // largest windows, then a short one that closes at once
        write_window(-1);
        send_levels('{1'b0, 1'b0, 1'b1, 1'b1, 1'b0});
        wait_drained();
        write_window(600000000);
        send_levels('{1'b1, 1'b1});
        wait_drained();
        write_window(2);
        send_levels('{1'b1});
        wait_drained();

        send_idle_pct  = 38;
        recv_stall_pct = 60;
        pulse_phase(7, 100, 6);
        pulse_phase(1, 60, 3);

        send_idle_pct  = 60;
        recv_stall_pct = 38;
        pulse_phase(40, 100, 25);
        pulse_phase(0, 60, 3);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pulse_phase(3, 60, 2);
        pulse_phase(1000, 1010, 300);

        if (tracker.pending.size() != 0)
            $error("%0d window results never arrived", tracker.pending.size());
        $display("covered %0d ticks and %0d window results, %0d of them at full occupancy,",
                 tracker.ticks, tracker.windows, tracker.saturated);
        $display("over window lengths from 0 up to the 30-bit maximum");
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("tb_dust_low_pulse_occupancy passed");
        else
            $display("tb_dust_low_pulse_occupancy failed");
        $finish;
    end

endmodule
